// ===== rtl/gfs_pkg.sv =====
// Shared constants for the Gaussian FIR smoother.
package gfs_pkg;

    // Default sizing of the filter.
    localparam int MAX_RADIUS_DEF  = 6;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed register and counter sizes.
    localparam int NUM_COEF     = 7;
    localparam int COEF_BITS    = 18;
    localparam int RAD_BITS     = 3;
    localparam int CNT_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int Q_SHIFT      = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BASE = 3'd1;

    // Center weight after reset is 1.0 in Q1.17.
    localparam logic [COEF_BITS-1:0] COEF0_RESET = 18'd131072;

    typedef logic [COEF_BITS-1:0] t_coef;

endpackage

// ===== rtl/gaussian_fir_smoother_unit.sv =====
// Streaming symmetric Gaussian FIR smoother with half-sample mirrored edges.
// Pipeline: taps latch at the accepting edge, then multiply, group add, final add, round and
// saturate into the output register. Throughput: one item per cycle unless the output stalls;
// results trail the input by R samples, and an item marked last releases the results still
// owed (at most MAX_RADIUS+1), one per cycle unless the output stalls, while input is held
// off. Reset (synchronous, active low) clears counters, window, pipeline valids and loads
// radius 0, center weight 1.0 and all other weights 0.
module gaussian_fir_smoother_unit #(
    parameter int MAX_RADIUS  = gfs_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = gfs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gfs_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [gfs_pkg::COEF_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_end_of_spectrum,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_smoothed,
    output logic                              o_final_res
);
    import gfs_pkg::*;

    localparam int WIN      = 2 * MAX_RADIUS + 1;
    localparam int WIN_W    = $clog2(WIN);
    localparam int LANE_RAD = (MAX_RADIUS < NUM_COEF - 1) ? MAX_RADIUS : NUM_COEF - 1;
    localparam int LANES    = 2 * LANE_RAD + 1;
    localparam int LAG_W    = $clog2(MAX_RADIUS + 1);
    localparam int PS_W     = $clog2(LANE_RAD + 1);
    localparam int OFF_W    = $clog2(4 * MAX_RADIUS + 8) + 2;
    localparam int PROD_W   = SAMPLE_BITS + COEF_BITS + 1;
    localparam int GRP      = 4;
    localparam int NGRP     = (LANES + GRP - 1) / GRP;
    localparam int GRP_W    = PROD_W + 2;
    localparam int ACC_W    = GRP_W + $clog2(NGRP + 1);
    localparam int RW       = ACC_W + 1;

    localparam logic signed [OFF_W-1:0] OFF_ZERO = OFF_W'(0);
    localparam logic signed [OFF_W-1:0] OFF_ONE  = OFF_W'(1);
    localparam logic signed [OFF_W-1:0] OFF_WMAX = OFF_W'(WIN - 1);
    localparam logic signed [RW-1:0] RND_HALF = RW'(64'sd1 <<< (Q_SHIFT - 1));
    localparam logic signed [RW-1:0] SAT_MAX  = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_MIN  = ~SAT_MAX;

    // Configuration, window and spectrum counters.
    logic [RAD_BITS-1:0]           r_radius;
    t_coef                         r_coef [NUM_COEF];
    logic signed [SAMPLE_BITS-1:0] r_win [WIN];
    logic [CNT_BITS-1:0]           r_seen;
    logic [CNT_BITS-1:0]           r_emit;
    logic                          r_flush;
    logic [LAG_W-1:0]              r_flush_lag;

    // Pipeline registers.
    logic                          r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic                          r_s1_final, r_s2_final, r_s3_final, r_s4_final;
    logic                          r_out_final;
    logic signed [SAMPLE_BITS-1:0] r_s1_tap [LANES];
    t_coef                         r_s1_coef [LANES];
    logic signed [PROD_W-1:0]      r_s2_prod [LANES];
    logic signed [GRP_W-1:0]       r_s3_grp [NGRP];
    logic signed [ACC_W-1:0]       r_s4_sum;
    logic signed [SAMPLE_BITS-1:0] r_out_smoothed;

    // Front-end signals.
    logic                          w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic                          w_acc;
    logic [CNT_BITS-1:0]           w_diff;
    logic [LAG_W-1:0]              w_lag_in;
    logic [RAD_BITS-1:0]           w_eff_r;
    logic                          w_lag_ge_r;
    logic                          w_issue;
    logic [LAG_W-1:0]              w_iss_lag;
    logic                          w_iss_final;
    logic [PS_W-1:0]               w_ps;
    logic signed [SAMPLE_BITS-1:0] w_src [WIN];
    logic [WIN_W-1:0]              w_bidx [LANES];
    logic signed [SAMPLE_BITS-1:0] w_tap [LANES];
    t_coef                         w_lcoef [LANES];
    logic signed [PROD_W-1:0]      w_prod_pad [NGRP*GRP];
    logic signed [GRP_W-1:0]       w_grp [NGRP];
    logic signed [ACC_W-1:0]       w_sum;
    logic signed [RW-1:0]          w_rnd;
    logic signed [RW-1:0]          w_shr;
    logic signed [RW-1:0]          w_sat;

    // Ready chain: a stage loads when it is empty or its content moves on.
    assign w_rdy5 = !r_out_v || i_out_ready;
    assign w_rdy4 = !r_s4_v || w_rdy5;
    assign w_rdy3 = !r_s3_v || w_rdy4;
    assign w_rdy2 = !r_s2_v || w_rdy3;
    assign w_rdy1 = !r_s1_v || w_rdy2;

    assign o_in_ready = !r_flush && w_rdy1;
    assign w_acc      = i_in_valid && o_in_ready;

    // Lag of the oldest owed result and the effective radius.
    assign w_diff     = r_seen - r_emit;
    assign w_lag_in   = (w_diff > CNT_BITS'(MAX_RADIUS)) ? LAG_W'(MAX_RADIUS)
                                                        : w_diff[LAG_W-1:0];
    assign w_eff_r    = (r_radius > RAD_BITS'(LANE_RAD)) ? RAD_BITS'(LANE_RAD) : r_radius;
    assign w_lag_ge_r = CNT_BITS'(w_lag_in) >= CNT_BITS'(w_eff_r);

    // A result is issued for an item with enough look-ahead, a last item, or each flush step.
    assign w_issue     = (w_acc && (i_end_of_spectrum || w_lag_ge_r)) || (r_flush && w_rdy1);
    assign w_iss_lag   = r_flush ? r_flush_lag : w_lag_in;
    assign w_iss_final = r_flush ? (r_flush_lag == '0)
                                 : (i_end_of_spectrum && (w_lag_in == '0));
    assign w_ps        = (r_emit > CNT_BITS'(LANE_RAD)) ? PS_W'(LANE_RAD) : r_emit[PS_W-1:0];

    // Window as it stands once the current item is taken in.
    always_comb begin
        w_src[0] = w_acc ? i_sample : r_win[0];
        for (int j = 1; j < WIN; j++) begin
            w_src[j] = w_acc ? r_win[j-1] : r_win[j];
        end
    end

    // Per-lane tap select with mirror reflection and clamping at both edges.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam logic signed [OFF_W-1:0] KK = OFF_W'(l - LANE_RAD);
        localparam int TAP_D = (l < LANE_RAD) ? LANE_RAD - l : l - LANE_RAD;

        always_comb begin : p_back
            logic signed [OFF_W-1:0] psv;
            logic signed [OFF_W-1:0] lg;
            logic signed [OFF_W-1:0] off;
            logic signed [OFF_W-1:0] bk;
            psv = OFF_W'(w_ps);
            lg  = OFF_W'(w_iss_lag);
            if ((psv + KK) < OFF_ZERO) begin
                off = OFF_ZERO - psv - psv - KK - OFF_ONE;
            end else if (KK > lg) begin
                off = lg + lg + OFF_ONE - KK;
            end else begin
                off = KK;
            end
            if ((psv + off) < OFF_ZERO) begin
                off = OFF_ZERO - psv;
            end
            if (off > lg) begin
                off = lg;
            end
            bk = lg - off;
            if (bk < OFF_ZERO) begin
                bk = OFF_ZERO;
            end else if (bk > OFF_WMAX) begin
                bk = OFF_WMAX;
            end
            w_bidx[l] = bk[WIN_W-1:0];
        end

        assign w_tap[l]   = w_src[w_bidx[l]];
        assign w_lcoef[l] = (RAD_BITS'(TAP_D) <= w_eff_r) ? r_coef[TAP_D] : '0;
    end

    // Zero padding so every adder group has the same shape.
    for (genvar i = 0; i < NGRP * GRP; i++) begin : g_pad
        if (i < LANES) begin : g_used
            assign w_prod_pad[i] = r_s2_prod[i];
        end else begin : g_zero
            assign w_prod_pad[i] = '0;
        end
    end

    // Group sums of the products.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int i = 0; i < GRP; i++) begin
                w_grp[g] = w_grp[g] + GRP_W'(w_prod_pad[g*GRP+i]);
            end
        end
    end

    // Total of the group sums.
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_sum = w_sum + ACC_W'(r_s3_grp[g]);
        end
    end

    // Round half up, drop the fraction and saturate.
    assign w_rnd = RW'(r_s4_sum) + RND_HALF;
    assign w_shr = w_rnd >>> Q_SHIFT;
    always_comb begin
        if (w_shr > SAT_MAX) begin
            w_sat = SAT_MAX;
        end else if (w_shr < SAT_MIN) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_shr;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_coef[0] <= COEF0_RESET;
            for (int c = 1; c < NUM_COEF; c++) begin
                r_coef[c] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_RADIUS) begin
                r_radius <= i_cfg_data[RAD_BITS-1:0];
            end else begin
                r_coef[i_cfg_idx - CFG_COEF_BASE] <= i_cfg_data;
            end
        end
    end

    // Window, spectrum counters and flush sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WIN; j++) begin
                r_win[j] <= '0;
            end
            r_seen      <= '0;
            r_emit      <= '0;
            r_flush     <= 1'b0;
            r_flush_lag <= '0;
        end else if (w_acc) begin
            r_win <= w_src;
            if (!i_end_of_spectrum) begin
                r_seen <= r_seen + CNT_BITS'(1);
                if (w_lag_ge_r) begin
                    r_emit <= r_emit + CNT_BITS'(1);
                end
            end else if (w_lag_in == '0) begin
                r_seen <= '0;
                r_emit <= '0;
            end else begin
                r_flush     <= 1'b1;
                r_flush_lag <= w_lag_in - LAG_W'(1);
                r_emit      <= r_emit + CNT_BITS'(1);
            end
        end else if (r_flush && w_rdy1) begin
            if (r_flush_lag == '0) begin
                r_flush <= 1'b0;
                r_seen  <= '0;
                r_emit  <= '0;
            end else begin
                r_flush_lag <= r_flush_lag - LAG_W'(1);
                r_emit      <= r_emit + CNT_BITS'(1);
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_v  <= w_issue;
            if (w_rdy2) r_s2_v  <= r_s1_v;
            if (w_rdy3) r_s3_v  <= r_s2_v;
            if (w_rdy4) r_s4_v  <= r_s3_v;
            if (w_rdy5) r_out_v <= r_s4_v;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && w_issue) begin
            r_s1_tap   <= w_tap;
            r_s1_coef  <= w_lcoef;
            r_s1_final <= w_iss_final;
        end
        if (w_rdy2 && r_s1_v) begin
            for (int l = 0; l < LANES; l++) begin
                r_s2_prod[l] <= r_s1_tap[l] * $signed({1'b0, r_s1_coef[l]});
            end
            r_s2_final <= r_s1_final;
        end
        if (w_rdy3 && r_s2_v) begin
            r_s3_grp   <= w_grp;
            r_s3_final <= r_s2_final;
        end
        if (w_rdy4 && r_s3_v) begin
            r_s4_sum   <= w_sum;
            r_s4_final <= r_s3_final;
        end
        if (w_rdy5 && r_s4_v) begin
            r_out_smoothed <= w_sat[SAMPLE_BITS-1:0];
            r_out_final    <= r_s4_final;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_smoothed  = r_out_smoothed;
    assign o_final_res = r_out_final;

    // The flush owns the issue slot, so no item may be taken meanwhile.
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !o_in_ready)
        else $error("item accepted during flush");

    // A last item either starts a flush or closes the spectrum at once.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_end_of_spectrum) |=> (r_flush || (r_seen == '0 && r_emit == '0)))
        else $error("last item left counters open");

    // The final flush step ends the flush and clears the counters.
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && w_rdy1 && r_flush_lag == '0) |=>
            (!r_flush && r_seen == '0 && r_emit == '0))
        else $error("flush did not end cleanly");

    // Every flush step issues a result into the pipeline.
    a_flush_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && w_rdy1) |=> r_s1_v)
        else $error("flush step lost its result");

endmodule
